// ===== sv/irlp_pkg.sv =====
// shared types and constants for the index range list parser
`timescale 1ns / 1ps

package irlp_pkg;

    localparam int IDX_W = 21;
    localparam int ACC_W = IDX_W + 1;

    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic KIND_RANGE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_valid;
        logic       end_of_text;
    } irlp_in_t;

    typedef struct packed {
        logic             result_kind;
        logic [IDX_W-1:0] range_first;
        logic [IDX_W-1:0] range_last;
        logic             parse_error;
        logic             last;
    } irlp_out_t;

    // one parsed word worth of work for the back end: a range, a status, or both
    typedef struct packed {
        logic             has_range;
        logic             has_status;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
        logic             error;
    } irlp_entry_t;

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_HYPHEN = 4'b0100,
        PH_SECOND = 4'b1000
    } irlp_phase_t;

endpackage

// ===== sv/index_range_list_parser_core.sv =====
// top level of the index range list parser: front end, entry queue, back end
//
//  port group     direction  contents
//  s_*            in         one text character per word, with valid and end marks
//  m_*            out        range word (first, last) or final status word
//  cfg_wr_*       in         index limit register write
//
// the front end takes one character per cycle while the queue is not full; its
// multiply-by-ten accumulate and bound compares settle in that cycle
// a character that closes a range and ends the text makes two output words,
// so the back end loads the range word first and then the status word; all other entries make one
// the queue lets characters keep arriving while m_ready is low, until it fills
// reset (aresetn low, synchronous) clears parse state and sets the index limit to 99
`timescale 1ns / 1ps

module index_range_list_parser_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [irlp_pkg::IDX_W-1:0] cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  irlp_pkg::irlp_in_t     s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output irlp_pkg::irlp_out_t    m_data
);
    import irlp_pkg::*;

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_empty;
    irlp_entry_t q_in;
    irlp_entry_t q_head;

    irlp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    irlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    irlp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== sv/irlp_front.sv =====
// parser front end: takes characters, tracks parse state, emits work entries
`timescale 1ns / 1ps

module irlp_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [irlp_pkg::IDX_W-1:0] cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  irlp_pkg::irlp_in_t     s_data,
    input  logic                   q_full,
    output logic                   q_push,
    output irlp_pkg::irlp_entry_t  q_data
);
    import irlp_pkg::*;

    logic [IDX_W-1:0] limit_reg;
    irlp_phase_t      phase_reg, phase_next, phase_mid;
    logic [ACC_W-1:0] acc_reg, acc_next, acc_mid;
    logic             digits_reg, digits_next, digits_mid;
    logic [IDX_W-1:0] start_reg, start_next, start_mid;
    logic             aborted_reg, aborted_next, aborted_mid;

    logic [ACC_W-1:0] lim;
    logic [ACC_W-1:0] cap;
    logic [ACC_W+3:0] prod;
    logic [7:0]       c;
    logic             is_digit;
    logic             accept;
    logic             comma_bad;
    logic             comma_rng;
    logic             end_bad;
    logic             end_rng;
    logic             at_end;

    assign lim      = {1'b0, limit_reg};
    assign cap      = lim + ACC_W'(1);
    assign c        = s_data.char_code;
    assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign at_end   = s_data.end_of_text;

    // acc * 10 + digit
    assign prod = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                + (ACC_W+4)'(c - CHAR_ZERO);

    assign comma_bad = (acc_reg > lim) ||
                       ((phase_reg == PH_SECOND) && ({1'b0, start_reg} > acc_reg));

    always_comb begin
        phase_mid   = phase_reg;
        acc_mid     = acc_reg;
        digits_mid  = digits_reg;
        start_mid   = start_reg;
        aborted_mid = aborted_reg;
        comma_rng   = 1'b0;
        if (s_data.char_valid && !aborted_reg) begin
            priority if (is_digit) begin
                if (phase_reg == PH_START) begin
                    phase_mid = PH_FIRST;
                end else if (phase_reg == PH_HYPHEN) begin
                    phase_mid = PH_SECOND;
                end
                acc_mid    = (prod > {4'b0000, cap}) ? cap : prod[ACC_W-1:0];
                digits_mid = 1'b1;
            end else if ((c == CHAR_DASH) && (phase_reg == PH_FIRST)) begin
                if (acc_reg > lim) begin
                    aborted_mid = 1'b1;
                end else begin
                    start_mid  = acc_reg[IDX_W-1:0];
                    acc_mid    = '0;
                    digits_mid = 1'b0;
                    phase_mid  = PH_HYPHEN;
                end
            end else if (c == CHAR_COMMA) begin
                if ((phase_reg != PH_FIRST) && (phase_reg != PH_SECOND)) begin
                    aborted_mid = 1'b1;
                end else if (comma_bad) begin
                    aborted_mid = 1'b1;
                end else begin
                    comma_rng  = 1'b1;
                    acc_mid    = '0;
                    digits_mid = 1'b0;
                    phase_mid  = PH_START;
                end
            end else if (c == CHAR_SPACE) begin
            end else begin
                aborted_mid = 1'b1;
            end
        end
    end

    // closing the last number at end of text, on the state after the character
    assign end_bad = (acc_mid > lim) ||
                     ((phase_mid == PH_SECOND) && ({1'b0, start_mid} > acc_mid));
    assign end_rng = at_end && !aborted_mid && digits_mid && !end_bad;

    always_comb begin
        q_data.has_range  = comma_rng || end_rng;
        q_data.has_status = at_end;
        q_data.error      = aborted_mid || (digits_mid && end_bad);
        if (comma_rng) begin
            q_data.first = (phase_reg == PH_SECOND) ? start_reg : acc_reg[IDX_W-1:0];
            q_data.last  = acc_reg[IDX_W-1:0];
        end else begin
            q_data.first = (phase_mid == PH_SECOND) ? start_mid : acc_mid[IDX_W-1:0];
            q_data.last  = acc_mid[IDX_W-1:0];
        end
    end

    assign q_push = accept && (comma_rng || at_end);

    always_comb begin
        phase_next   = phase_mid;
        acc_next     = acc_mid;
        digits_next  = digits_mid;
        start_next   = start_mid;
        aborted_next = aborted_mid;
        if (at_end) begin
            phase_next   = PH_START;
            acc_next     = '0;
            digits_next  = 1'b0;
            start_next   = '0;
            aborted_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= IDX_W'(99);
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            digits_reg    <= 1'b0;
            start_reg     <= '0;
            aborted_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                digits_reg  <= digits_next;
                start_reg   <= start_next;
                aborted_reg <= aborted_next;
            end
        end
    end

endmodule

// ===== sv/irlp_queue.sv =====
// small register queue of work entries between front and back end
`timescale 1ns / 1ps

module irlp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  irlp_pkg::irlp_entry_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output irlp_pkg::irlp_entry_t head
);
    import irlp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    irlp_entry_t   mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/irlp_back.sv =====
// back end: turns queued entries into range and status words in an output register
`timescale 1ns / 1ps

module irlp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  irlp_pkg::irlp_entry_t q_head,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output irlp_pkg::irlp_out_t   m_data
);
    import irlp_pkg::*;

    logic      m_valid_reg, m_valid_next;
    irlp_out_t m_data_reg, m_data_next;
    logic      range_done_reg, range_done_next;
    logic      load;
    logic      send_range;

    assign load       = !q_empty && (!m_valid_reg || m_ready);
    assign send_range = q_head.has_range && !range_done_reg;
    // the entry leaves once its final word is loaded into the output register
    assign q_pop      = load && (!send_range || !q_head.has_status);

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        range_done_next = range_done_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            if (send_range) begin
                m_data_next.result_kind = KIND_RANGE;
                m_data_next.range_first = q_head.first;
                m_data_next.range_last  = q_head.last;
                m_data_next.parse_error = 1'b0;
                m_data_next.last        = 1'b0;
            end else begin
                m_data_next.result_kind = KIND_STATUS;
                m_data_next.range_first = '0;
                m_data_next.range_last  = '0;
                m_data_next.parse_error = q_head.error;
                m_data_next.last        = 1'b1;
            end
            range_done_next = send_range && q_head.has_status;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            range_done_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            range_done_reg <= range_done_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
